// ===== sv/wtsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wtsd_pkg
// Shared types and fixed field widths for the weighted tardiness subset DP.
// ----------------------------------------------------------------------------
package wtsd_pkg;

  localparam int PROC_W   = 10;
  localparam int WEIGHT_W = 8;
  localparam int DUE_W    = 16;
  localparam int VALUE_W  = 32;
  localparam int IN_DATA_W = 40;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SUM,
    S_CAND,
    S_DRAIN,
    S_WRITE,
    S_BREAD,
    S_BSTORE,
    S_EMIT_COST,
    S_EMIT_JOB
  } state_t;

  // control from the sequencer to the evaluation datapath
  typedef struct packed {
    logic load;       // store the incoming job
    logic sum_en;     // accumulate completion time
    logic sum_first;  // first step of the sum pass, also clears the minimum
    logic issue;      // candidate issue step
  } eval_ctl_t;

endpackage

// ===== sv/wtsd_ram.sv =====
// ----------------------------------------------------------------------------
// wtsd_ram
// Generic single-port RAM, write-first-free, registered read.
// ----------------------------------------------------------------------------
module wtsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/wtsd_eval.sv =====
// ----------------------------------------------------------------------------
// wtsd_eval
// Job register file, completion-time sum, tardiness term and running minimum.
// ----------------------------------------------------------------------------
module wtsd_eval
  import wtsd_pkg::*;
#(
  parameter int MAX_JOBS  = 12,
  parameter int COST_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eval_ctl_t            ctl,
  input  logic [(MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1)-1:0] wr_idx,
  input  logic [PROC_W-1:0]    wr_time,
  input  logic [WEIGHT_W-1:0]  wr_weight,
  input  logic [DUE_W-1:0]     wr_due,
  input  logic [(MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1)-1:0] j_idx,
  input  logic                 member,
  input  logic [COST_BITS-1:0] cost_rdata,
  output logic [COST_BITS-1:0] best_cost,
  output logic [(MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1)-1:0] best_j
);

  localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS * ((1 << PROC_W) - 1) + 1);
  localparam int DW = (CW > DUE_W) ? CW : DUE_W;
  localparam int PW = DW + WEIGHT_W;
  localparam int XW = (PW > COST_BITS) ? PW : COST_BITS;

  logic [PROC_W-1:0]   time_r   [MAX_JOBS];
  logic [WEIGHT_W-1:0] weight_r [MAX_JOBS];
  logic [DUE_W-1:0]    due_r    [MAX_JOBS];

  logic [CW-1:0]        c_r;
  logic                 p_valid_r;
  logic [JW-1:0]        p_j_r;
  logic [COST_BITS-1:0] term_r;
  logic                 have_r;
  logic [COST_BITS-1:0] best_r;
  logic [JW-1:0]        best_j_r;

  logic [COST_BITS-1:0] lim;
  logic [DW-1:0]        c_x, d_x, diff;
  logic [PW-1:0]        prod;
  logic [XW-1:0]        prod_x;
  logic [COST_BITS-1:0] term;
  logic [COST_BITS:0]   sum;
  logic [COST_BITS-1:0] cand;
  logic                 take;

  always_comb begin
    lim    = {COST_BITS{1'b1}};
    c_x    = DW'(c_r);
    d_x    = DW'(due_r[j_idx]);
    diff   = (c_x > d_x) ? (c_x - d_x) : '0;
    prod   = PW'(diff) * PW'(weight_r[j_idx]);
    prod_x = XW'(prod);
    term   = (prod_x > XW'(lim)) ? lim : COST_BITS'(prod_x);
    // saturating add of the term and the cost of the subset without j
    sum    = {1'b0, term_r} + {1'b0, cost_rdata};
    cand   = sum[COST_BITS] ? lim : sum[COST_BITS-1:0];
    take   = p_valid_r && (!have_r || (cand < best_r));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      time_r[wr_idx]   <= wr_time;
      weight_r[wr_idx] <= wr_weight;
      due_r[wr_idx]    <= wr_due;
    end
    if (ctl.sum_en) begin
      c_r <= (ctl.sum_first ? '0 : c_r) + (member ? CW'(time_r[j_idx]) : '0);
    end
    if (ctl.issue) begin
      p_j_r  <= j_idx;
      term_r <= term;
    end
    if (take) begin
      best_r   <= cand;
      best_j_r <= p_j_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      have_r    <= 1'b0;
    end else begin
      p_valid_r <= ctl.issue && member;
      if (ctl.sum_en && ctl.sum_first) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
    end
  end

  assign best_cost = best_r;
  assign best_j    = best_j_r;

endmodule

// ===== sv/weighted_tardiness_subset_dp.sv =====
// ----------------------------------------------------------------------------
// weighted_tardiness_subset_dp
// Exact single-machine weighted tardiness scheduler by subset dynamic program.
// ----------------------------------------------------------------------------
// Jobs arrive one item per cycle while the block is idle; jobs past MAX_JOBS
// are dropped. The item with tlast starts a run over the n stored jobs.
// Every nonempty subset is visited in increasing order: a sum pass over the
// n jobs for the completion time, a candidate pass issuing one read of the
// single-port cost RAM per job, one drain step and one write-back step.
// After the backtrack, n+1 result items follow: the total cost (tuser = 0),
// then the 1-based job numbers in processing order (tuser = 1, tlast on the
// final one). The subset RAMs need no clearing pass: every entry whose value
// is used is written before it is read. New jobs are not taken until the
// last result item of a run has been loaded into the output register.
// ----------------------------------------------------------------------------
module weighted_tardiness_subset_dp
  import wtsd_pkg::*;
#(
  parameter int MAX_JOBS  = 12,
  parameter int COST_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // proc_time[9:0], weight[17:10], due_date[33:18]
  input  logic                 in_tlast,   // last_job
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [VALUE_W-1:0]   out_tdata,  // value[31:0]
  output logic [0:0]           out_tuser,  // is_job[0]
  output logic                 out_tlast   // last
);

  localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int NW = $clog2(MAX_JOBS + 1);
  localparam int SW = MAX_JOBS;

  state_t state_r, state_nxt;

  logic [NW-1:0]      count_r, count_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [SW-1:0]      full_r, full_nxt;
  logic [SW-1:0]      s_r, s_nxt;
  logic [JW-1:0]      j_r, j_nxt;
  logic [NW-1:0]      k_r, k_nxt;
  logic [NW-1:0]      i_r, i_nxt;
  logic [JW-1:0]      order_r [MAX_JOBS];

  logic               out_valid_r, out_valid_nxt;
  logic               out_is_job_r, out_is_job_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc;
  logic               slot_free;
  logic [NW-1:0]      n_new;
  logic [SW:0]        full_wide;
  logic               j_last;
  logic [SW-1:0]      j_mask;
  logic [SW-1:0]      bt_mask;
  logic [NW-1:0]      k_m1;
  logic               order_we;

  eval_ctl_t          ctl;
  logic               ram_we;
  logic [SW-1:0]      ram_addr;
  logic               ram_init;
  logic [COST_BITS-1:0] cost_wdata, cost_rdata, best_cost;
  logic [JW-1:0]      last_wdata, last_rdata, best_j;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;

  assign n_new      = (count_r < NW'(MAX_JOBS)) ? (count_r + NW'(1)) : count_r;
  assign full_wide  = ((SW + 1)'(1) << n_new) - (SW + 1)'(1);
  assign j_last     = (NW'(j_r) == (n_r - NW'(1)));
  assign j_mask     = SW'(1) << j_r;
  assign bt_mask    = SW'(1) << last_rdata;
  assign k_m1       = k_r - NW'(1);

  assign cost_wdata = ram_init ? '0 : best_cost;
  assign last_wdata = ram_init ? '0 : best_j;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    full_nxt       = full_r;
    s_nxt          = s_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_is_job_nxt = out_is_job_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    ctl            = '0;
    ram_we         = 1'b0;
    ram_init       = 1'b0;
    ram_addr       = s_r;
    order_we       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ctl.load = (count_r < NW'(MAX_JOBS));
          if (in_tlast) begin
            n_nxt     = n_new;
            full_nxt  = full_wide[SW-1:0];
            count_nxt = '0;
            state_nxt = S_INIT;
          end else begin
            count_nxt = n_new;
          end
        end
      end
      S_INIT: begin
        // empty subset costs nothing
        ram_we    = 1'b1;
        ram_init  = 1'b1;
        ram_addr  = '0;
        s_nxt     = SW'(1);
        j_nxt     = '0;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        ctl.sum_en    = 1'b1;
        ctl.sum_first = (j_r == '0);
        if (j_last) begin
          j_nxt     = '0;
          state_nxt = S_CAND;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      S_CAND: begin
        ctl.issue = 1'b1;
        ram_addr  = s_r & ~j_mask;
        if (j_last) begin
          j_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        ram_we = 1'b1;
        if (s_r == full_r) begin
          k_nxt     = n_r;
          state_nxt = S_BREAD;
        end else begin
          s_nxt     = s_r + SW'(1);
          state_nxt = S_SUM;
        end
      end
      S_BREAD: begin
        state_nxt = S_BSTORE;
      end
      S_BSTORE: begin
        // backtrack: the stored last job goes at position k-1
        order_we = 1'b1;
        s_nxt    = s_r & ~bt_mask;
        k_nxt    = k_m1;
        if (k_r == NW'(1)) begin
          state_nxt = S_EMIT_COST;
        end else begin
          state_nxt = S_BREAD;
        end
      end
      S_EMIT_COST: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_is_job_nxt = 1'b0;
          out_value_nxt  = VALUE_W'(best_cost);
          out_last_nxt   = (n_r == '0);
          i_nxt          = '0;
          state_nxt      = S_EMIT_JOB;
        end
      end
      S_EMIT_JOB: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_is_job_nxt = 1'b1;
          out_value_nxt  = VALUE_W'(order_r[i_r[JW-1:0]]) + VALUE_W'(1);
          out_last_nxt   = (i_r == (n_r - NW'(1)));
          i_nxt          = i_r + NW'(1);
          if (i_r == (n_r - NW'(1))) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    full_r       <= full_nxt;
    s_r          <= s_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    i_r          <= i_nxt;
    out_is_job_r <= out_is_job_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    if (order_we) begin
      order_r[k_m1[JW-1:0]] <= last_rdata;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_is_job_r;
  assign out_tlast    = out_last_r;

  wtsd_eval #(
    .MAX_JOBS  (MAX_JOBS),
    .COST_BITS (COST_BITS)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .wr_idx     (count_r[JW-1:0]),
    .wr_time    (in_tdata[9:0]),
    .wr_weight  (in_tdata[17:10]),
    .wr_due     (in_tdata[33:18]),
    .j_idx      (j_r),
    .member     (s_r[j_r]),
    .cost_rdata (cost_rdata),
    .best_cost  (best_cost),
    .best_j     (best_j)
  );

  // subset cost table
  wtsd_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (1 << MAX_JOBS)
  ) u_cost_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cost_wdata),
    .rdata (cost_rdata)
  );

  // chosen last job per subset
  wtsd_ram #(
    .WIDTH (JW),
    .DEPTH (1 << MAX_JOBS)
  ) u_last_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (last_wdata),
    .rdata (last_rdata)
  );

  // job counter never passes the store depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_JOBS))
    else $error("job count out of range");

  // a marked item always kicks off a run
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (state_r == S_INIT))
    else $error("run did not start");

  // backtracked job must still be a member of the remaining subset
  a_bt_member: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BSTORE) |-> ((s_r & bt_mask) != '0))
    else $error("backtrack picked a job outside the subset");

  // backtrack ends with every job removed
  a_bt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_COST && $past(state_r) == S_BSTORE) |-> (s_r == '0))
    else $error("backtrack left jobs behind");

  // the cost item never closes a run
  a_cost_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_job_r) |-> !out_last_r)
    else $error("cost item marked last");

endmodule
